// ===== hw/rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, register indexes and phase codes of the lift sequence
// controller.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned ServoW   = 7;
  localparam int unsigned PhaseW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FOLD_DRIVE_SPEED = 3'd0,
    REG_RAISE_SPEED      = 3'd1,
    REG_LOWER_SPEED      = 3'd2,
    REG_TEARDOWN_SPEED   = 3'd3,
    REG_SERVO_OPEN       = 3'd4,
    REG_SERVO_HALF       = 3'd5
  } cfg_idx_t;

  typedef enum logic [PhaseW-1:0] {
    PH_EMERGENCY   = 4'd0,
    PH_IDLE        = 4'd1,
    PH_UNFOLD      = 4'd2,
    PH_UNFOLDED    = 4'd3,
    PH_RAISE       = 4'd4,
    PH_AT_TOP      = 4'd5,
    PH_LOWER       = 4'd6,
    PH_AT_MIDDLE   = 4'd7,
    PH_RAISE_MORE  = 4'd8,
    PH_TEARDOWN    = 4'd9,
    PH_TORN_TOP    = 4'd10,
    PH_RETURN_HOME = 4'd11
  } phase_t;

  localparam logic signed [DriveW-1:0] FoldSpeedReset     = 8'sd80;
  localparam logic signed [DriveW-1:0] RaiseSpeedReset    = 8'sd80;
  localparam logic signed [DriveW-1:0] LowerSpeedReset    = -8'sd50;
  localparam logic signed [DriveW-1:0] TeardownSpeedReset = 8'sd20;
  localparam logic [ServoW-1:0]        ServoOpenReset     = 7'd90;
  localparam logic [ServoW-1:0]        ServoHalfReset     = 7'd50;

  typedef struct packed {
    logic signed [DriveW-1:0] fold_drive_speed;
    logic signed [DriveW-1:0] raise_speed;
    logic signed [DriveW-1:0] lower_speed;
    logic signed [DriveW-1:0] teardown_speed;
    logic [ServoW-1:0]        servo_open;
    logic [ServoW-1:0]        servo_half;
  } cfg_t;

  typedef struct packed {
    logic estop_pressed;
    logic fold_button;
    logic build_button;
    logic teardown_button;
    logic place_button;
    logic home_limit;
    logic top_limit;
    logic middle_switch;
    logic unfolded_switch;
  } poll_t;

  typedef struct packed {
    phase_t                   phase;
    logic signed [DriveW-1:0] fold_level;
    logic signed [DriveW-1:0] lift_level;
    logic [ServoW-1:0]        servo_level;
    logic                     lamp_lit;
  } seq_state_t;

  typedef struct packed {
    seq_state_t state;
    logic       lights;
    logic       buzz;
  } step_res_t;

endpackage

// ===== hw/rtl/lsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsc_cfg_regs
// Register file for the speed and servo settings, written one word at a time.
// ----------------------------------------------------------------------------
module lsc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [lsc_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [lsc_pkg::CfgDataW-1:0]  wr_data,
  output lsc_pkg::cfg_t                 cfg
);
  import lsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_FOLD_DRIVE_SPEED: cfg_nxt.fold_drive_speed = wr_data;
        REG_RAISE_SPEED:      cfg_nxt.raise_speed      = wr_data;
        REG_LOWER_SPEED:      cfg_nxt.lower_speed      = wr_data;
        REG_TEARDOWN_SPEED:   cfg_nxt.teardown_speed   = wr_data;
        REG_SERVO_OPEN:       cfg_nxt.servo_open       = wr_data[ServoW-1:0];
        REG_SERVO_HALF:       cfg_nxt.servo_half       = wr_data[ServoW-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fold_drive_speed <= FoldSpeedReset;
      cfg_r.raise_speed      <= RaiseSpeedReset;
      cfg_r.lower_speed      <= LowerSpeedReset;
      cfg_r.teardown_speed   <= TeardownSpeedReset;
      cfg_r.servo_open       <= ServoOpenReset;
      cfg_r.servo_half       <= ServoHalfReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/lsc_step.sv =====
// ----------------------------------------------------------------------------
// lsc_step
// Next-state and action logic of the lift sequence for one poll.
// ----------------------------------------------------------------------------
module lsc_step (
  input  lsc_pkg::seq_state_t cur,
  input  lsc_pkg::poll_t      poll,
  input  lsc_pkg::cfg_t       cfg,
  output lsc_pkg::step_res_t  res
);
  import lsc_pkg::*;

  phase_t run_phase;

  always_comb begin
    run_phase = poll.estop_pressed ? PH_EMERGENCY : cur.phase;
    res.state = cur;
    res.lights = 1'b0;
    res.buzz = poll.estop_pressed;
    if (poll.estop_pressed) begin
      res.state.lamp_lit = 1'b1;
    end
    res.state.phase = run_phase;

    case (run_phase)
      PH_IDLE: begin
        res.state.servo_level = '0;
        res.state.fold_level = '0;
        res.state.lift_level = '0;
        if (poll.fold_button) res.state.phase = PH_UNFOLD;
      end
      PH_UNFOLD: begin
        res.state.fold_level = cfg.fold_drive_speed;
        res.lights = 1'b1;
        res.buzz = 1'b1;
        if (poll.unfolded_switch) res.state.phase = PH_UNFOLDED;
      end
      PH_UNFOLDED: begin
        res.state.fold_level = '0;
        if (poll.build_button) res.state.phase = PH_RAISE;
      end
      PH_RAISE: begin
        res.state.servo_level = cfg.servo_open;
        res.state.lift_level = cfg.raise_speed;
        res.lights = 1'b1;
        res.buzz = 1'b1;
        if (poll.top_limit) res.state.phase = PH_AT_TOP;
      end
      PH_AT_TOP: begin
        res.state.lift_level = '0;
        if (poll.place_button) res.state.phase = PH_LOWER;
      end
      PH_LOWER: begin
        res.state.lift_level = cfg.lower_speed;
        res.lights = 1'b1;
        res.buzz = 1'b1;
        if (poll.middle_switch) res.state.phase = PH_AT_MIDDLE;
      end
      PH_AT_MIDDLE: begin
        res.state.lift_level = '0;
        res.state.servo_level = '0;
        if (poll.teardown_button) begin
          res.state.phase = PH_TEARDOWN;
        end else if (poll.build_button) begin
          res.state.phase = PH_RAISE_MORE;
        end
      end
      PH_RAISE_MORE: begin
        res.state.lift_level = cfg.raise_speed;
        res.lights = 1'b1;
        res.buzz = 1'b1;
        if (poll.home_limit) res.state.phase = PH_RAISE;
      end
      PH_TEARDOWN: begin
        res.state.servo_level = cfg.servo_half;
        res.state.lift_level = cfg.teardown_speed;
        res.lights = 1'b1;
        res.buzz = 1'b1;
        if (poll.top_limit) res.state.phase = PH_TORN_TOP;
      end
      PH_TORN_TOP: begin
        if (poll.place_button) res.state.phase = PH_RETURN_HOME;
      end
      PH_RETURN_HOME: begin
        res.lights = 1'b1;
        res.buzz = 1'b1;
        if (poll.home_limit) res.state.phase = PH_UNFOLDED;
      end
      default: begin
        res.lights = 1'b1;
        res.state.fold_level = '0;
        res.state.lift_level = '0;
        res.state.phase = PH_EMERGENCY;
        if (!poll.estop_pressed) begin
          res.state.lamp_lit = 1'b0;
          res.state.phase = PH_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/lift_sequence_controller.sv =====
// ----------------------------------------------------------------------------
// lift_sequence_controller
// Scaffold lift sequencer: one poll of e-stop, buttons and limit switches in,
// one word of phase, held drive and servo levels and lamp requests out.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    estop, four buttons, four limit switches
//   out      out_valid/out_stall  phase, fold/lift drive, servo, lights/buzzer/lamp
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A poll is registered, then the sequence logic updates the state and loads
// the result register, one poll per cycle while the result side takes words.
// A word is accepted every cycle while the result side keeps taking words.
// Synchronous reset returns the emergency phase, zero levels and register
// defaults. A stalled result holds the input register, which then stalls.
// ----------------------------------------------------------------------------
module lift_sequence_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_estop_pressed,
  input  logic                                in_fold_button,
  input  logic                                in_build_button,
  input  logic                                in_teardown_button,
  input  logic                                in_place_button,
  input  logic                                in_home_limit,
  input  logic                                in_top_limit,
  input  logic                                in_middle_switch,
  input  logic                                in_unfolded_switch,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lsc_pkg::PhaseW-1:0]          out_phase_now,
  output logic signed [lsc_pkg::DriveW-1:0]   out_fold_drive,
  output logic signed [lsc_pkg::DriveW-1:0]   out_lift_drive,
  output logic [lsc_pkg::ServoW-1:0]          out_servo_position,
  output logic                                out_lights_on,
  output logic                                out_buzzer_on,
  output logic                                out_estop_lamp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [lsc_pkg::CfgDataW-1:0]        cfg_data
);
  import lsc_pkg::*;

  cfg_t       cfg;
  poll_t      poll_r;
  logic       poll_valid_r;
  logic       poll_valid_nxt;
  seq_state_t state_r;
  step_res_t  step;
  step_res_t  res_r;
  logic       res_valid_r;
  logic       res_valid_nxt;
  logic       res_open;
  logic       poll_move;
  logic       in_accept;

  assign cfg_ready = 1'b1;

  lsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign res_open  = !res_valid_r || !out_stall;
  assign poll_move = poll_valid_r && res_open;
  assign in_stall  = poll_valid_r && !res_open;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    poll_valid_nxt = poll_valid_r;
    if (in_accept) begin
      poll_valid_nxt = 1'b1;
    end else if (poll_move) begin
      poll_valid_nxt = 1'b0;
    end
    res_valid_nxt = res_valid_r;
    if (poll_move) begin
      res_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      poll_r <= '{in_estop_pressed, in_fold_button, in_build_button,
                  in_teardown_button, in_place_button, in_home_limit,
                  in_top_limit, in_middle_switch, in_unfolded_switch};
    end
    if (poll_move) begin
      res_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      poll_valid_r <= poll_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  lsc_step u_step (
    .cur  (state_r),
    .poll (poll_r),
    .cfg  (cfg),
    .res  (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_EMERGENCY;
      state_r.fold_level  <= '0;
      state_r.lift_level  <= '0;
      state_r.servo_level <= '0;
      state_r.lamp_lit    <= 1'b0;
    end else if (poll_move) begin
      state_r <= step.state;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_phase_now      = res_r.state.phase;
  assign out_fold_drive     = res_r.state.fold_level;
  assign out_lift_drive     = res_r.state.lift_level;
  assign out_servo_position = res_r.state.servo_level;
  assign out_lights_on      = res_r.lights;
  assign out_buzzer_on      = res_r.buzz;
  assign out_estop_lamp     = res_r.state.lamp_lit;

  a_emergency_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase_now == PH_EMERGENCY) |->
      (out_estop_lamp && out_buzzer_on && out_fold_drive == '0 && out_lift_drive == '0))
    else $error("emergency word without lamp, buzzer or stopped drives");

  a_idle_lamp_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase_now == PH_IDLE) |-> !out_estop_lamp)
    else $error("lamp still lit after leaving the emergency phase");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (poll_valid_r && res_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
    poll_move |=> (res_valid_r && res_r.state == state_r))
    else $error("result word and sequence state disagree");

endmodule
